// File: hdl/pthc_pkg.sv
`default_nettype none

package pthc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEMP       = 3'd0;
    localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] CFG_MIXED      = 3'd3;
    localparam logic [2:0] CFG_HUM        = 3'd4;

    // Pipeline shape
    localparam int unsigned NUM_STAGES = 44;
    localparam int unsigned DIV_FIRST  = 9;
    localparam int unsigned DIV_STEPS  = 32;

    localparam logic [31:0] K_T_OFS    = 32'd128;
    localparam logic [31:0] K_P_OFS    = 32'd64000;
    localparam logic [31:0] K_P_ONE    = 32'd32768;
    localparam logic [31:0] K_P_FULL   = 32'd1048576;
    localparam logic [31:0] K_P_SCALE  = 32'd3125;
    localparam logic [31:0] K_H_OFS    = 32'd76800;
    localparam logic [31:0] K_H_RND    = 32'd16384;
    localparam logic [31:0] K_H_ONE    = 32'd32768;
    localparam logic [31:0] K_H_BIAS   = 32'd2097152;
    localparam logic [31:0] K_H_RND2   = 32'd8192;
    localparam logic [31:0] K_H_MAX    = 32'd419430400;

    typedef struct packed {
        logic        vld;
        logic [19:0] ap;
        logic [15:0] ah;
        logic [31:0] a1;
        logic [31:0] dd;
        logic [31:0] ta;
        logic [31:0] b0;
        logic [31:0] tfine;
        logic [31:0] tpre;
        logic [31:0] pa;
        logic [31:0] v;
        logic [31:0] temp;
        logic [31:0] qq;
        logic [31:0] m5;
        logic [31:0] m2;
        logic [31:0] mh5;
        logic [31:0] mh6;
        logic [31:0] mh3;
        logic [31:0] b;
        logic [31:0] a;
        logic [31:0] x;
        logic [31:0] y1;
        logic [31:0] bb;
        logic [31:0] aa;
        logic [31:0] y2;
        logic [31:0] am;
        logic [31:0] pnum;
        logic [31:0] yh;
        logic [31:0] divisor;
        logic        inv;
        logic        mode;
        logic [32:0] rem;
        logic [31:0] quo;
        logic [31:0] hv;
        logic [31:0] ss;
        logic [31:0] hh;
        logic [16:0] hum;
        logic [31:0] p;
        logic [31:0] pp;
        logic [31:0] e0;
        logic [31:0] c0;
        logic [31:0] press;
    } t_pipe;

    function automatic logic [31:0] f_sra(input logic [31:0] x, input logic [4:0] s);
        f_sra = $unsigned($signed(x) >>> s);
    endfunction

endpackage

`default_nettype wire

// File: hdl/pth_sensor_compensation.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// in        request    i_in_valid / o_in_ready     i_raw_temp, i_raw_press, i_raw_hum
// out       result     o_out_valid / i_out_ready   o_temp_centideg, o_press_pa,
//                                                  o_hum_q22_10, o_press_invalid
// cfg       write      i_cfg_we                    i_cfg_index, i_cfg_data
//
// One request enters per cycle while o_in_ready is high. The 32-step restoring
// pressure divider forms one quotient bit per stage. Synchronous active-low
// reset clears every stage valid bit and the coefficient registers. The whole
// pipe advances together: when the last stage holds a result that is not
// taken, every stage holds.

module pth_sensor_compensation (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire        [19:0] i_raw_temp,
    input  wire        [19:0] i_raw_press,
    input  wire        [15:0] i_raw_hum,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [31:0] o_temp_centideg,
    output logic       [31:0] o_press_pa,
    output logic       [16:0] o_hum_q22_10,
    output logic              o_press_invalid,
    input  wire               i_cfg_we,
    input  wire         [2:0] i_cfg_index,
    input  wire        [63:0] i_cfg_data
);

    // Factory trim registers
    logic [47:0] r_temp_c;
    logic [63:0] r_plow_c;
    logic [63:0] r_phigh_c;
    logic [47:0] r_mixed_c;
    logic [31:0] r_hum_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_c  <= '0;
            r_plow_c  <= '0;
            r_phigh_c <= '0;
            r_mixed_c <= '0;
            r_hum_c   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pthc_pkg::CFG_TEMP:       r_temp_c  <= i_cfg_data[47:0];
                pthc_pkg::CFG_PRESS_LOW:  r_plow_c  <= i_cfg_data;
                pthc_pkg::CFG_PRESS_HIGH: r_phigh_c <= i_cfg_data;
                pthc_pkg::CFG_MIXED:      r_mixed_c <= i_cfg_data[47:0];
                pthc_pkg::CFG_HUM:        r_hum_c   <= i_cfg_data[31:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Unpack coefficients to 32-bit two's complement words
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, r_temp_c[15:0]};
    assign t2 = {{16{r_temp_c[31]}}, r_temp_c[31:16]};
    assign t3 = {{16{r_temp_c[47]}}, r_temp_c[47:32]};
    assign p1 = {16'd0, r_plow_c[15:0]};
    assign p2 = {{16{r_plow_c[31]}}, r_plow_c[31:16]};
    assign p3 = {{16{r_plow_c[47]}}, r_plow_c[47:32]};
    assign p4 = {{16{r_plow_c[63]}}, r_plow_c[63:48]};
    assign p5 = {{16{r_phigh_c[15]}}, r_phigh_c[15:0]};
    assign p6 = {{16{r_phigh_c[31]}}, r_phigh_c[31:16]};
    assign p7 = {{16{r_phigh_c[47]}}, r_phigh_c[47:32]};
    assign p8 = {{16{r_phigh_c[63]}}, r_phigh_c[63:48]};
    assign p9 = {{16{r_mixed_c[15]}}, r_mixed_c[15:0]};
    assign h1 = {24'd0, r_mixed_c[23:16]};
    assign h2 = {{16{r_mixed_c[39]}}, r_mixed_c[39:24]};
    assign h3 = {24'd0, r_mixed_c[47:40]};
    assign h4 = {{20{r_hum_c[11]}}, r_hum_c[11:0]};
    assign h5 = {{20{r_hum_c[23]}}, r_hum_c[23:12]};
    assign h6 = {{24{r_hum_c[31]}}, r_hum_c[31:24]};

    pthc_pkg::t_pipe r_s [pthc_pkg::NUM_STAGES];
    pthc_pkg::t_pipe n_s [pthc_pkg::NUM_STAGES];

    logic        adv;
    logic [31:0] at32;
    logic [31:0] d0;
    logic [31:0] hs;
    logic [31:0] hv2;
    logic [32:0] dtry;
    logic        dge;

    // Advance whenever the output slot is free or being emptied
    assign adv        = !r_s[pthc_pkg::NUM_STAGES-1].vld || i_out_ready;
    assign o_in_ready = adv;

    always_comb begin
        at32 = {12'd0, i_raw_temp};
        d0   = (at32 >> 4) - t1;
        hs   = '0;
        hv2  = '0;
        dtry = '0;
        dge  = 1'b0;

        // Stage 0: first temperature products
        n_s[0]     = r_s[0];
        n_s[0].vld = i_in_valid;
        n_s[0].ap  = i_raw_press;
        n_s[0].ah  = i_raw_hum;
        n_s[0].a1  = ((at32 >> 3) - (t1 << 1)) * t2;
        n_s[0].dd  = d0 * d0;

        for (int k = 1; k < pthc_pkg::NUM_STAGES; k++) begin
            n_s[k] = r_s[k-1];
        end

        // Temperature
        n_s[1].ta    = pthc_pkg::f_sra(r_s[0].a1, 5'd11);
        n_s[1].b0    = pthc_pkg::f_sra(r_s[0].dd, 5'd12) * t3;
        n_s[2].tfine = r_s[1].ta + pthc_pkg::f_sra(r_s[1].b0, 5'd14);
        n_s[3].tpre  = r_s[2].tfine * 32'd5 + pthc_pkg::K_T_OFS;
        n_s[3].pa    = pthc_pkg::f_sra(r_s[2].tfine, 5'd1) - pthc_pkg::K_P_OFS;
        n_s[3].v     = r_s[2].tfine - pthc_pkg::K_H_OFS;
        n_s[4].temp  = pthc_pkg::f_sra(r_s[3].tpre, 5'd8);

        // Pressure and humidity products of the fine temperature
        n_s[4].qq  = pthc_pkg::f_sra(r_s[3].pa, 5'd2) * pthc_pkg::f_sra(r_s[3].pa, 5'd2);
        n_s[4].m5  = r_s[3].pa * p5;
        n_s[4].m2  = p2 * r_s[3].pa;
        n_s[4].mh5 = h5 * r_s[3].v;
        n_s[4].mh6 = r_s[3].v * h6;
        n_s[4].mh3 = r_s[3].v * h3;

        n_s[5].b  = pthc_pkg::f_sra(r_s[4].qq, 5'd11) * p6;
        n_s[5].a  = p3 * pthc_pkg::f_sra(r_s[4].qq, 5'd13);
        n_s[5].x  = pthc_pkg::f_sra(({16'd0, r_s[4].ah} << 14) - (h4 << 20) - r_s[4].mh5
                                    + pthc_pkg::K_H_RND, 5'd15);
        n_s[5].y1 = pthc_pkg::f_sra(r_s[4].mh6, 5'd10)
                    * (pthc_pkg::f_sra(r_s[4].mh3, 5'd11) + pthc_pkg::K_H_ONE);

        n_s[6].bb = pthc_pkg::f_sra(r_s[5].b + (r_s[5].m5 << 1), 5'd2) + (p4 << 16);
        n_s[6].aa = pthc_pkg::f_sra(pthc_pkg::f_sra(r_s[5].a, 5'd3)
                                    + pthc_pkg::f_sra(r_s[5].m2, 5'd1), 5'd18);
        n_s[6].y2 = (pthc_pkg::f_sra(r_s[5].y1, 5'd10) + pthc_pkg::K_H_BIAS) * h2;

        n_s[7].am   = (pthc_pkg::K_P_ONE + r_s[6].aa) * p1;
        n_s[7].pnum = ((pthc_pkg::K_P_FULL - {12'd0, r_s[6].ap})
                      - pthc_pkg::f_sra(r_s[6].bb, 5'd12)) * pthc_pkg::K_P_SCALE;
        n_s[7].yh   = pthc_pkg::f_sra(r_s[6].y2 + pthc_pkg::K_H_RND2, 5'd14);

        // Divider setup: fold the doubling before or after the divide
        n_s[8].divisor = pthc_pkg::f_sra(r_s[7].am, 5'd15);
        n_s[8].inv     = (pthc_pkg::f_sra(r_s[7].am, 5'd15) == 32'd0);
        n_s[8].mode    = r_s[7].pnum[31];
        n_s[8].quo     = r_s[7].pnum[31] ? r_s[7].pnum : (r_s[7].pnum << 1);
        n_s[8].rem     = '0;
        n_s[8].hv      = r_s[7].x * r_s[7].yh;

        // Restoring divide, one quotient bit per stage
        for (int k = pthc_pkg::DIV_FIRST; k < pthc_pkg::DIV_FIRST + pthc_pkg::DIV_STEPS;
             k++) begin
            dtry = {r_s[k-1].rem[31:0], r_s[k-1].quo[31]};
            dge  = (dtry >= {1'b0, r_s[k-1].divisor});
            n_s[k].rem = dge ? (dtry - {1'b0, r_s[k-1].divisor}) : dtry;
            n_s[k].quo = {r_s[k-1].quo[30:0], dge};
        end

        // Humidity tail, alongside the divider
        hs          = pthc_pkg::f_sra(r_s[8].hv, 5'd15);
        n_s[9].ss   = hs * hs;
        n_s[10].hh  = pthc_pkg::f_sra(r_s[9].ss, 5'd7) * h1;
        hv2         = r_s[10].hv - pthc_pkg::f_sra(r_s[10].hh, 5'd4);
        if (hv2[31]) begin
            n_s[11].hum = '0;
        end else if (hv2 > pthc_pkg::K_H_MAX) begin
            n_s[11].hum = pthc_pkg::K_H_MAX[28:12];
        end else begin
            n_s[11].hum = hv2[28:12];
        end

        // Pressure correction
        n_s[41].p  = r_s[40].mode ? (r_s[40].quo << 1) : r_s[40].quo;
        n_s[41].pp = (n_s[41].p >> 3) * (n_s[41].p >> 3);
        n_s[41].e0 = (n_s[41].p >> 2) * p8;
        n_s[42].c0 = p9 * (r_s[41].pp >> 13);
        n_s[43].press = r_s[42].inv ? 32'd0
                      : r_s[42].p + pthc_pkg::f_sra(pthc_pkg::f_sra(r_s[42].c0, 5'd12)
                                                    + pthc_pkg::f_sra(r_s[42].e0, 5'd13)
                                                    + p7, 5'd4);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < pthc_pkg::NUM_STAGES; k++) begin
            if (!i_rst_n) begin
                r_s[k].vld <= 1'b0;
            end else if (adv) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_out_valid     = r_s[pthc_pkg::NUM_STAGES-1].vld;
    assign o_temp_centideg = $signed(r_s[pthc_pkg::NUM_STAGES-1].temp);
    assign o_press_pa      = r_s[pthc_pkg::NUM_STAGES-1].press;
    assign o_hum_q22_10    = r_s[pthc_pkg::NUM_STAGES-1].hum;
    assign o_press_invalid = r_s[pthc_pkg::NUM_STAGES-1].inv;

endmodule

`default_nettype wire
